@@ rtl/cse_pkg.sv @@
// Shared types and constants of the cubic spline evaluator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package cse_pkg;

  // Horner accumulator width; holds cub*dx^3 plus the scaled lower terms
  localparam int MW = 136;

  // configuration register indexes
  localparam logic [1:0] CFG_NUM_KNOTS   = 2'd0;
  localparam logic [1:0] CFG_EQUAL_SPACE = 2'd1;
  localparam logic [1:0] CFG_INV_SPACING = 2'd2;

  // region codes
  localparam logic [1:0] REGION_INSIDE = 2'd0;
  localparam logic [1:0] REGION_BELOW  = 2'd1;
  localparam logic [1:0] REGION_ABOVE  = 2'd2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  typedef struct packed {
    logic [8:0]  num_knots;
    logic        direct_index;
    logic [31:0] inv_spacing;
  } cfg_t;

  // one queued word, already classified
  typedef struct packed {
    op_t                op;
    logic               wr_ok;
    logic [7:0]         entry_index;
    logic signed [31:0] knot_pos;
    logic signed [31:0] knot_value;
    logic signed [31:0] coef_lin;
    logic signed [31:0] coef_quad;
    logic signed [31:0] coef_cub;
    logic signed [31:0] arg_x;
  } item_t;

endpackage
`default_nettype wire

@@ rtl/cubic_spline_evaluator_core.sv @@
// Top level of the cubic spline evaluator: configuration registers,
// front queue and back end. Depends on cse_pkg, cse_front, cse_back.
//
// Usage:
//   Command channel: a word is taken on a clock edge with start high and
//   busy low. cmd 0 writes one segment entry (knot, value, coefficients)
//   and gives no result; cmd 1 evaluates the spline at arg_x.
//   Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
//   index 0 num_knots, 1 direct_index, 2 inv_spacing. cfg_ready is always
//   high; write only while no evaluation is pending.
//   Results: y_out, segment and region appear for one cycle with done high.
//   The receiver cannot stall; results are never held.
// Timing:
//   A word enters a two-word queue; the idle back end pops it in the next
//   cycle. A write is stored in the table as it is popped and leaves the
//   back end idle. Inside the range, an evaluation finds its segment from
//   the index in direct-index mode, else by a binary search of up to eight
//   steps for 256 knots. The back end ends one evaluation before it pops
//   the next word, and may pop it while done is high. Three Horner passes
//   through one 32x33 multiplier and the single table read port bound the
//   evaluation rate. busy is high while both queue entries are full.
// Reset: clears the queue, the sequencer and the configuration registers
//   (num_knots 2, direct_index 0, inv_spacing 1.0); the table keeps its data.
`timescale 1ns / 1ps
`default_nettype none
module cubic_spline_evaluator_core #(
  parameter int MAX_KNOTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic [7:0]         entry_index,
  input  logic signed [31:0] knot_pos,
  input  logic signed [31:0] knot_value,
  input  logic signed [31:0] coef_lin,
  input  logic signed [31:0] coef_quad,
  input  logic signed [31:0] coef_cub,
  input  logic signed [31:0] arg_x,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] y_out,
  output logic [7:0]         segment,
  output logic [1:0]         region
);
  import cse_pkg::*;

  cfg_t  cfg;
  item_t head;
  logic  head_valid, pop;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_knots    <= 9'd2;
      cfg.direct_index <= 1'b0;
      cfg.inv_spacing  <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NUM_KNOTS:   cfg.num_knots    <= cfg_data[8:0];
        CFG_EQUAL_SPACE: cfg.direct_index <= cfg_data[0];
        CFG_INV_SPACING: cfg.inv_spacing  <= cfg_data;
        default: ;
      endcase
    end
  end

  cse_front #(.MAX_KNOTS(MAX_KNOTS)) u_front (
    .clk, .rst, .start, .busy, .cmd, .entry_index, .knot_pos, .knot_value,
    .coef_lin, .coef_quad, .coef_cub, .arg_x,
    .head, .head_valid, .pop
  );

  cse_back #(.MAX_KNOTS(MAX_KNOTS)) u_back (
    .clk, .rst, .cfg, .head, .head_valid, .pop,
    .done, .y_out, .segment, .region
  );

endmodule
`default_nettype wire

@@ rtl/cse_front.sv @@
// Front end: takes command words, classifies them and holds them in a
// two-entry queue for the back end. Depends on cse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cse_front #(
  parameter int MAX_KNOTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic [7:0]         entry_index,
  input  logic signed [31:0] knot_pos,
  input  logic signed [31:0] knot_value,
  input  logic signed [31:0] coef_lin,
  input  logic signed [31:0] coef_quad,
  input  logic signed [31:0] coef_cub,
  input  logic signed [31:0] arg_x,
  output cse_pkg::item_t     head,
  output logic               head_valid,
  input  logic               pop
);
  import cse_pkg::*;

  item_t       slots [2];
  item_t       new_item;
  logic        wptr, rptr;
  logic [1:0]  count;
  logic        push, pop_ok;

  // classify the incoming word
  always_comb begin
    new_item.op          = op_t'(cmd);
    new_item.wr_ok       = (32'(entry_index) < MAX_KNOTS);
    new_item.entry_index = entry_index;
    new_item.knot_pos    = knot_pos;
    new_item.knot_value  = knot_value;
    new_item.coef_lin    = coef_lin;
    new_item.coef_quad   = coef_quad;
    new_item.coef_cub    = coef_cub;
    new_item.arg_x       = arg_x;
  end

  assign busy       = (count == 2'd2);
  assign push       = start && !busy;
  assign head_valid = (count != 2'd0);
  assign pop_ok     = pop && head_valid;
  assign head       = slots[rptr];

  // queue pointers and storage
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        slots[wptr] <= new_item;
        wptr        <= ~wptr;
      end
      if (pop_ok) rptr <= ~rptr;
      case ({push, pop_ok})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/cse_back.sv @@
// Back end: segment table, segment lookup and Horner evaluation with a
// chunked 32x33 multiplier. Depends on cse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cse_back #(
  parameter int MAX_KNOTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  cse_pkg::cfg_t      cfg,
  input  cse_pkg::item_t     head,
  input  logic               head_valid,
  output logic               pop,
  output logic               done,
  output logic signed [31:0] y_out,
  output logic [7:0]         segment,
  output logic [1:0]         region
);
  import cse_pkg::*;

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int NW = ($clog2(MAX_KNOTS + 1) > 9) ? $clog2(MAX_KNOTS + 1) : 9;

  typedef struct packed {
    logic signed [31:0] knot;
    logic signed [31:0] value;
    logic signed [31:0] lin;
    logic signed [31:0] quad;
    logic signed [31:0] cub;
  } entry_t;

  typedef enum logic [14:0] {
    ST_IDLE     = 15'b000000000000001,
    ST_RD_FIRST = 15'b000000000000010,
    ST_RD_LAST  = 15'b000000000000100,
    ST_CLASSIFY = 15'b000000000001000,
    ST_ABOVE    = 15'b000000000010000,
    ST_EQ_MUL   = 15'b000000000100000,
    ST_EQ_IDX   = 15'b000000001000000,
    ST_SEARCH   = 15'b000000010000000,
    ST_SRCH_CMP = 15'b000000100000000,
    ST_RD_SEG   = 15'b000001000000000,
    ST_SEG_LOAD = 15'b000010000000000,
    ST_PMAG     = 15'b000100000000000,
    ST_PMUL     = 15'b001000000000000,
    ST_PADD     = 15'b010000000000000,
    ST_OUT      = 15'b100000000000000
  } state_t;

  state_t              state;
  entry_t              mem [MAX_KNOTS];
  entry_t              rd_q;
  entry_t              wr_data;
  logic [AW-1:0]       rd_addr;
  logic                we;

  logic [NW-1:0]       n_raw, n_cl;
  logic [AW-1:0]       n_m1, n_m2;

  logic signed [31:0]  x, k0, val0, lin0, val_r, lin_r, quad_r;
  logic signed [32:0]  dx;
  logic [32:0]         dxmag;
  logic [AW-1:0]       lo, hi, idx;
  logic [AW:0]         mid_sum;
  logic [AW-1:0]       mid;
  logic [31:0]         eq_diff;
  logic [63:0]         eq_prod;
  logic [MW-1:0]       m_acc, mag, acc, addend;
  logic [64:0]         prod;
  logic                neg;
  logic [2:0]          cnt;
  logic [1:0]          st;
  logic [31:0]         chunk;
  logic [MW-1:0]       prod_sh;
  logic                fits;

  // knot count clamped to the table
  assign n_raw = NW'(cfg.num_knots);
  always_comb begin
    if (n_raw < NW'(2))              n_cl = NW'(2);
    else if (n_raw > NW'(MAX_KNOTS)) n_cl = NW'(MAX_KNOTS);
    else                             n_cl = n_raw;
  end
  assign n_m1 = AW'(n_cl - NW'(1));
  assign n_m2 = AW'(n_cl - NW'(2));

  assign mid_sum = {1'b0, lo} + {1'b0, hi} + (AW + 1)'(1);
  assign mid     = mid_sum[AW:1];

  // distance from the first knot, positive inside the range
  assign eq_diff = 32'({x[31], x} - {k0[31], k0});

  assign pop = (state == ST_IDLE) && head_valid;
  assign we  = pop && (head.op == OP_WRITE) && head.wr_ok;

  always_comb begin
    wr_data.knot  = head.knot_pos;
    wr_data.value = head.knot_value;
    wr_data.lin   = head.coef_lin;
    wr_data.quad  = head.coef_quad;
    wr_data.cub   = head.coef_cub;
  end

  // table read address by state
  always_comb begin
    unique case (state)
      ST_RD_FIRST: rd_addr = '0;
      ST_RD_LAST:  rd_addr = n_m1;
      ST_CLASSIFY: rd_addr = n_m2;
      ST_SEARCH:   rd_addr = mid;
      ST_RD_SEG:   rd_addr = idx;
      default:     rd_addr = '0;
    endcase
  end

  // segment table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[AW'(head.entry_index)] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // Horner addend for the current stage
  always_comb begin
    case (st)
      2'd0:    addend = MW'({{(MW - 32){quad_r[31]}}, quad_r}) << 16;
      2'd1:    addend = MW'({{(MW - 32){lin_r[31]}}, lin_r}) << 32;
      default: addend = (MW'({{(MW - 32){val_r[31]}}, val_r}) << 48)
                        + (MW'(1) << 47);
    endcase
  end

  // multiplier chunk and product placement
  always_comb begin
    case (cnt[1:0])
      2'd0:    chunk = mag[31:0];
      2'd1:    chunk = mag[63:32];
      2'd2:    chunk = mag[95:64];
      default: chunk = mag[127:96];
    endcase
    case (cnt)
      3'd1:    prod_sh = MW'(prod);
      3'd2:    prod_sh = MW'(prod) << 32;
      3'd3:    prod_sh = MW'(prod) << 64;
      default: prod_sh = MW'(prod) << 96;
    endcase
  end

  // result bits [79:48] fit when everything above bit 79 is sign
  assign fits = (&m_acc[MW-1:79]) || !(|m_acc[MW-1:79]);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (pop && head.op == OP_EVAL) begin
            x     <= head.arg_x;
            state <= ST_RD_FIRST;
          end
        end
        ST_RD_FIRST: state <= ST_RD_LAST;
        ST_RD_LAST: begin
          k0    <= rd_q.knot;
          val0  <= rd_q.value;
          lin0  <= rd_q.lin;
          state <= ST_CLASSIFY;
        end
        ST_CLASSIFY: begin
          quad_r <= '0;
          if (x <= k0) begin
            val_r   <= val0;
            lin_r   <= lin0;
            dx      <= {x[31], x} - {k0[31], k0};
            segment <= '0;
            region  <= REGION_BELOW;
            m_acc   <= '0;
            st      <= 2'd0;
            state   <= ST_PMAG;
          end else if (x >= rd_q.knot) begin
            val_r   <= rd_q.value;
            dx      <= {x[31], x} - {rd_q.knot[31], rd_q.knot};
            segment <= 8'(n_m2);
            region  <= REGION_ABOVE;
            state   <= ST_ABOVE;
          end else if (cfg.direct_index) begin
            state <= ST_EQ_MUL;
          end else begin
            lo    <= '0;
            hi    <= n_m2;
            state <= ST_SEARCH;
          end
        end
        ST_ABOVE: begin
          lin_r <= rd_q.lin;
          m_acc <= '0;
          st    <= 2'd0;
          state <= ST_PMAG;
        end
        ST_EQ_MUL: begin
          eq_prod <= 64'(eq_diff) * 64'(cfg.inv_spacing);
          state   <= ST_EQ_IDX;
        end
        ST_EQ_IDX: begin
          if (eq_prod[63:32] > 32'(n_m2)) idx <= n_m2;
          else                             idx <= AW'(eq_prod[63:32]);
          state <= ST_RD_SEG;
        end
        ST_SEARCH: begin
          if (lo < hi) begin
            state <= ST_SRCH_CMP;
          end else begin
            idx   <= lo;
            state <= ST_RD_SEG;
          end
        end
        ST_SRCH_CMP: begin
          if (rd_q.knot <= x) lo <= mid;
          else                hi <= mid - AW'(1);
          state <= ST_SEARCH;
        end
        ST_RD_SEG: state <= ST_SEG_LOAD;
        ST_SEG_LOAD: begin
          val_r   <= rd_q.value;
          lin_r   <= rd_q.lin;
          quad_r  <= rd_q.quad;
          dx      <= {x[31], x} - {rd_q.knot[31], rd_q.knot};
          m_acc   <= MW'({{(MW - 32){rd_q.cub[31]}}, rd_q.cub});
          segment <= 8'(idx);
          region  <= REGION_INSIDE;
          st      <= 2'd0;
          state   <= ST_PMAG;
        end
        // sign and magnitude of both factors
        ST_PMAG: begin
          mag   <= m_acc[MW-1] ? (~m_acc + MW'(1)) : m_acc;
          dxmag <= dx[32] ? 33'(-dx) : 33'(dx);
          neg   <= m_acc[MW-1] ^ dx[32];
          acc   <= '0;
          cnt   <= 3'd0;
          state <= ST_PMUL;
        end
        // four 32x33 partial products, each added in the cycle after it is formed
        ST_PMUL: begin
          if (cnt < 3'd4) prod <= 65'(chunk) * 65'(dxmag);
          if (cnt != 3'd0) acc <= acc + prod_sh;
          if (cnt == 3'd4) state <= ST_PADD;
          cnt <= cnt + 3'd1;
        end
        ST_PADD: begin
          m_acc <= neg ? (addend - acc) : (addend + acc);
          if (st == 2'd2) begin
            state <= ST_OUT;
          end else begin
            st    <= st + 2'd1;
            state <= ST_PMAG;
          end
        end
        // round already added; shift down and saturate
        ST_OUT: begin
          if (fits)             y_out <= m_acc[79:48];
          else if (m_acc[MW-1]) y_out <= 32'sh80000000;
          else                  y_out <= 32'sh7FFFFFFF;
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/cse_checker.sv @@
// Port-level checks for the cubic spline evaluator, bound to the top level.
// Depends on cubic_spline_evaluator_core and cse_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cse_checker (
  input logic       clk,
  input logic       rst,
  input logic       done,
  input logic [7:0] segment,
  input logic [1:0] region
);
  import cse_pkg::*;

  // no word survives reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result word right after reset");

  // an evaluation spans many cycles, so strobes never touch
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two result words in a row");

  a_region_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (region == REGION_INSIDE || region == REGION_BELOW || region == REGION_ABOVE))
    else $error("bad region code");

  a_below_seg: assert property (@(posedge clk) disable iff (rst)
    (done && region == REGION_BELOW) |-> segment == 8'd0)
    else $error("below-range word with nonzero segment");

endmodule

bind cubic_spline_evaluator_core cse_checker u_cse_checker (
  .clk(clk), .rst(rst), .done(done), .segment(segment), .region(region)
);
`default_nettype wire

@@ tb/cubic_spline_evaluator_core_tb.sv @@
// Self-checking testbench for cubic_spline_evaluator_core: table writes,
// evaluation in every region, both search modes, with a built-in predictor.
// Depends on cse_pkg and the RTL of the block.
`timescale 1ns / 1ps
module cubic_spline_evaluator_core_tb;
  import cse_pkg::*;

  localparam int NUM_ENTRIES = 256;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cmd = 1'b0;
  logic [7:0] entry_index = '0;
  logic signed [31:0] knot_pos = '0, knot_value = '0, coef_lin = '0;
  logic signed [31:0] coef_quad = '0, coef_cub = '0, arg_x = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic done;
  logic signed [31:0] y_out;
  logic [7:0] segment;
  logic [1:0] region;

  cubic_spline_evaluator_core dut (.*);

  always #2 clk = ~clk;

  // predictor copy of the segment table and registers
  logic signed [31:0] knot_mem [NUM_ENTRIES];
  logic signed [31:0] val_mem [NUM_ENTRIES];
  logic signed [31:0] lin_mem [NUM_ENTRIES];
  logic signed [31:0] quad_mem [NUM_ENTRIES];
  logic signed [31:0] cub_mem [NUM_ENTRIES];
  logic [8:0] knots_reg = 9'd2;
  logic spacing_mode = 1'b0;
  logic [31:0] recip_spacing = 32'd65536;

  typedef struct packed {
    logic signed [31:0] y;
    logic [7:0] seg;
    logic [1:0] reg_code;
  } spline_word_t;

  spline_word_t pending_evals[$];
  int errors = 0;
  int send_idle_pct = 0;

  // full-width polynomial, one rounding, then saturation
  function automatic spline_word_t eval_spline(logic signed [31:0] x);
    spline_word_t r;
    int n, idx, lo, hi, mid;
    logic signed [63:0] dx;
    logic signed [255:0] acc, q;
    logic [63:0] diff, prod;
    n = knots_reg;
    if (n < 2) n = 2;
    if (n > NUM_ENTRIES) n = NUM_ENTRIES;
    if (x <= knot_mem[0]) begin
      idx = 0;
      dx = 64'(x) - 64'(knot_mem[0]);
      acc = (256'(signed'(val_mem[0])) <<< 48) + ((256'(signed'(lin_mem[0])) * 256'(dx)) <<< 32);
      r.reg_code = REGION_BELOW;
    end else if (x >= knot_mem[n-1]) begin
      idx = n - 2;
      dx = 64'(x) - 64'(knot_mem[n-1]);
      acc = (256'(signed'(val_mem[n-1])) <<< 48)
          + ((256'(signed'(lin_mem[n-2])) * 256'(dx)) <<< 32);
      r.reg_code = REGION_ABOVE;
    end else begin
      if (spacing_mode) begin
        diff = 64'(x) - 64'(knot_mem[0]);
        prod = (diff * 64'(recip_spacing)) >> 32;
        idx = (prod > 64'(n - 2)) ? n - 2 : int'(prod);
      end else begin
        lo = 0;
        hi = n - 2;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          if (knot_mem[mid] <= x) lo = mid;
          else hi = mid - 1;
        end
        idx = lo;
      end
      dx = 64'(x) - 64'(knot_mem[idx]);
      acc = (256'(signed'(val_mem[idx])) <<< 48)
          + ((256'(signed'(lin_mem[idx])) * 256'(dx)) <<< 32)
          + ((256'(signed'(quad_mem[idx])) * 256'(dx) * 256'(dx)) <<< 16)
          + 256'(signed'(cub_mem[idx])) * 256'(dx) * 256'(dx) * 256'(dx);
      r.reg_code = REGION_INSIDE;
    end
    acc = acc + (256'sd1 <<< 47);
    q = acc >>> 48;
    if (q > 256'sh7FFFFFFF) r.y = 32'h7FFFFFFF;
    else if (q < -256'sh80000000) r.y = 32'h80000000;
    else r.y = q[31:0];
    r.seg = idx[7:0];
    return r;
  endfunction

  // one command word over the start/busy handshake; start stays high on
  // return so the next word can follow at once
  task automatic send_word(op_t op, logic [7:0] e, logic signed [31:0] kp,
                           logic signed [31:0] kv, logic signed [31:0] cl,
                           logic signed [31:0] cq, logic signed [31:0] cc,
                           logic signed [31:0] x);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd <= op;
    entry_index <= e;
    knot_pos <= kp;
    knot_value <= kv;
    coef_lin <= cl;
    coef_quad <= cq;
    coef_cub <= cc;
    arg_x <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_WRITE) begin
      knot_mem[e] = kp;
      val_mem[e] = kv;
      lin_mem[e] = cl;
      quad_mem[e] = cq;
      cub_mem[e] = cc;
    end else begin
      pending_evals.push_back(eval_spline(x));
    end
    @(negedge clk);
  endtask

  task automatic write_entry(int e, logic signed [31:0] kp);
    send_word(OP_WRITE, e[7:0], kp, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic eval_at(logic signed [31:0] x);
    send_word(OP_EVAL, 8'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, x);
  endtask

  // idle-only register write, after draining the block
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    start <= 1'b0;
    wait (pending_evals.size() == 0);
    repeat (50) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_NUM_KNOTS:   knots_reg = data[8:0];
      CFG_EQUAL_SPACE: spacing_mode = data[0];
      default:         recip_spacing = data;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // evenly spaced table; step is a power of two so inv_spacing is exact
  task automatic load_table(int n, int step_log2);
    logic signed [31:0] base;
    base = -(32'sd1 <<< (step_log2 + 2));
    for (int i = 0; i < n; i++) begin
      send_word(OP_WRITE, i[7:0], base + (i <<< step_log2),
                $urandom, $urandom_range(2, 0) == 0 ? $urandom : $urandom_range(65535, 0) - 32768,
                $urandom_range(1, 0) ? $urandom : 32'sd100, $urandom_range(1, 0) ? $urandom : -32'sd7,
                $urandom);
    end
  endtask

  function automatic logic signed [31:0] pick_x(int n);
    case ($urandom_range(9, 0))
      0: return $urandom;
      1: return knot_mem[0] - $urandom_range(3, 0);
      2: return knot_mem[n-1] + $urandom_range(3, 0);
      3: return knot_mem[$urandom_range(n - 1, 0)];
      default: return knot_mem[0] + 32'($urandom_range(0, 32'(knot_mem[n-1] - knot_mem[0])));
    endcase
  endfunction

  task automatic test_directed();
    write_reg(CFG_NUM_KNOTS, 32'd4);
    for (int i = 0; i < 4; i++)
      send_word(OP_WRITE, i[7:0], i * 32'sh10000, 32'sh7FFFFFFF, 32'sh80000000,
                32'sh7FFFFFFF, 32'sh80000000, '0);
    eval_at(32'sh80000000);
    eval_at(32'sh7FFFFFFF);
    eval_at(32'sh0);
    eval_at(32'sh30000);
    eval_at(32'sh18000);
    for (int i = 0; i < 4; i++)
      send_word(OP_WRITE, i[7:0], i * 32'sh10000, '0, 32'sh10000, '0, '0, '0);
    eval_at(32'sh8000);
    eval_at(32'sh28000);
    // knots not increasing
    send_word(OP_WRITE, 8'd2, -32'sh50000, 32'sh1234, 32'sh20000, 32'sh1, -32'sh1, '0);
    eval_at(32'sh18000);
    eval_at(32'sh2F000);
    write_reg(CFG_EQUAL_SPACE, 32'd1);
    write_reg(CFG_INV_SPACING, 32'd0);
    eval_at(32'sh28000);
    write_reg(CFG_INV_SPACING, 32'hFFFFFFFF);
    eval_at(32'sh18000);
    write_reg(CFG_INV_SPACING, 32'd65536);
    eval_at(32'sh18000);
    write_reg(CFG_EQUAL_SPACE, 32'd0);
    write_reg(CFG_NUM_KNOTS, 32'd0);
    eval_at(32'sh8000);
    write_reg(CFG_NUM_KNOTS, 32'd511);
    load_table(256, 8);
    eval_at(32'sh7FFFFFFF);
    eval_at(32'sh1000);
  endtask

  // knot step of 2^step_log2 LSBs needs inv_spacing 2^(32 - step_log2)
  task automatic test_random_phase(int n, bit mode, int step_log2, int count);
    write_reg(CFG_NUM_KNOTS, 32'(n));
    write_reg(CFG_EQUAL_SPACE, 32'(mode));
    write_reg(CFG_INV_SPACING, 32'(64'd1 << (32 - step_log2)));
    load_table(n, step_log2);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9, 0) == 0)
        write_entry($urandom_range(n - 1, 1), knot_mem[0] + 1 + $urandom_range(1 << (step_log2 + 4), 0));
      else
        eval_at(pick_x(n));
    end
  endtask

  // compare each done word against the oldest prediction
  always @(posedge clk) begin
    spline_word_t exp_w;
    if (!rst && done) begin
      if (pending_evals.size() == 0) begin
        $display("%0t: unexpected result y=%h seg=%0d region=%0d", $time, y_out, segment, region);
        errors++;
      end else begin
        exp_w = pending_evals.pop_front();
        if (y_out !== exp_w.y) begin
          $display("%0t: y_out expected %h actual %h", $time, exp_w.y, y_out);
          errors++;
        end
        if (segment !== exp_w.seg) begin
          $display("%0t: segment expected %0d actual %0d", $time, exp_w.seg, segment);
          errors++;
        end
        if (region !== exp_w.reg_code) begin
          $display("%0t: region expected %0d actual %0d", $time, exp_w.reg_code, region);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    send_idle_pct = 15;
    test_random_phase(2, 1'b0, 12, 150);
    test_random_phase(17, 1'b0, 10, 250);
    // sender waits for the block to drain
    start <= 1'b0;
    wait (pending_evals.size() == 0);
    send_idle_pct = 53;
    test_random_phase(9, 1'b1, 8, 250);
    test_random_phase(64, 1'b1, 14, 250);
    send_idle_pct = 0;
    test_random_phase(5, 1'b1, 16, 200);
    test_random_phase(256, 1'b0, 6, 300);
    start <= 1'b0;
    wait (pending_evals.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/cse_pkg.sv
rtl/cse_front.sv
rtl/cse_back.sv
rtl/cubic_spline_evaluator_core.sv
rtl/cse_checker.sv
tb/cubic_spline_evaluator_core_tb.sv
